### rtl/assert_macros.svh
// Assertion helpers used by support_threshold_dilate.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define STDIL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define STDIL_ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/stdil_pkg.sv
package stdil_pkg;

    localparam int MAX_LEN_DEF       = 32;
    localparam int VALUE_BITS_DEF    = 24;
    localparam int DILATE_RADIUS_DEF = 1;

    localparam int CUBE_LEN_W = 6;
    localparam int FRAC_W     = 16;
    localparam int TOTAL_W    = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CUBE_LEN_W-1:0] CUBE_LEN_RST = 6'd32;
    localparam logic [FRAC_W-1:0]     FRAC_RST     = 16'd1311;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_READ = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CUBE_LEN = 1'b0,
        CFG_FRACTION = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_SIZE1,
        ST_SIZE2,
        ST_IDLE,
        ST_RANGE,
        ST_MULT,
        ST_CUT,
        ST_THRESH,
        ST_DILATE
    } t_state;

    typedef enum logic [1:0] {
        AX_K,
        AX_J,
        AX_I
    } t_axis;

endpackage

### rtl/stdil_ram.sv
module stdil_ram #(
    parameter int W     = 1,
    parameter int DEPTH = 2,
    parameter int AW    = 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/support_threshold_dilate.sv
// Channel   | Direction | Handshake            | Payload
// request   | in        | start, busy          | i_cmd, i_voxel_value, i_support_bit
// result    | out       | o_valid              | o_new_support, o_last_voxel, o_support_total
// config    | in        | i_cfg_we             | i_cfg_index, i_cfg_data
//
// Loads and reads are taken one per cycle while busy is low; a read result passes through the
// r_q_valid and r_out_valid registers after its request and is shown for one cycle.
// The final load starts the update and keeps busy high through the range, threshold and
// dilation sweeps (T = 2*DILATE_RADIUS+1 taps per voxel), one memory read per cycle in each sweep.
// A cube_len write and reset keep busy high through ST_SIZE1 and ST_SIZE2 while the cube size is computed.
// The stores need no clearing after reset; the receiver cannot stall results.
module support_threshold_dilate #(
    parameter int MAX_LEN       = stdil_pkg::MAX_LEN_DEF,
    parameter int VALUE_BITS    = stdil_pkg::VALUE_BITS_DEF,
    parameter int DILATE_RADIUS = stdil_pkg::DILATE_RADIUS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_cmd,
    input  logic signed [VALUE_BITS-1:0]        i_voxel_value,
    input  logic                                i_support_bit,
    input  logic                                i_cfg_we,
    input  logic [stdil_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [stdil_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                                o_valid,
    output logic                                o_new_support,
    output logic                                o_last_voxel,
    output logic [stdil_pkg::TOTAL_W-1:0]       o_support_total
);

    import stdil_pkg::*;

    `include "assert_macros.svh"

    localparam int CELLS = MAX_LEN * MAX_LEN * MAX_LEN;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = AW + 1;
    localparam int LW    = $clog2(MAX_LEN + 1);
    localparam int XW    = $clog2(MAX_LEN);
    localparam int EW    = (LW > CUBE_LEN_W) ? LW : CUBE_LEN_W;
    localparam int NT    = 2 * DILATE_RADIUS + 1;
    localparam int TW    = (NT > 1) ? $clog2(NT) : 1;
    localparam int OW    = AW + 3;
    localparam int SW    = XW + TW + 1;
    localparam int PW    = VALUE_BITS + FRAC_W;
    localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

    // Configuration and cube size.
    logic [CUBE_LEN_W-1:0] r_cube_len;
    logic [FRAC_W-1:0]     r_frac;
    logic [LW-1:0]         r_edge;
    logic [2*LW-1:0]       r_plane;
    logic [CW-1:0]         r_cells;
    logic [EW-1:0]         len_ext;
    logic [LW-1:0]         edge_len;

    t_state r_state, n_state;

    // Load and readout positions.
    logic [AW-1:0]      r_load_pos;
    logic [AW-1:0]      r_read_pos;
    logic [TOTAL_W-1:0] r_count, n_count;
    logic               load_acc, read_acc, cfg_size_wr;
    logic [AW-1:0]      ld_pos, rd_pos;
    logic               ld_final, rd_wrap, rd_last;

    // Sweep engine.
    logic [AW-1:0]          r_pos;
    logic [XW-1:0]          r_ci, r_cj, r_ck;
    logic [TW-1:0]          r_tap;
    logic signed [OW-1:0]   r_off;
    t_axis                  r_axis;
    logic                   r_swept;
    logic                   is_dil, issue, last_tap, voxel_final, tap_ok;
    logic [XW-1:0]          coord_sel, edge_m1;
    logic [SW-1:0]          tap_sum;
    logic signed [OW-1:0]   cur_stride, base_cur, base_next;
    logic [AW-1:0]          sweep_addr;
    logic                   sweep_start;
    t_axis                  next_axis;

    // Returned-data stage.
    logic          r_p_valid, r_p_ok, r_p_last, r_p_final;
    logic [AW-1:0] r_p_addr;
    logic          p_done;
    logic          r_acc, hit;

    // Range and cutoff.
    logic signed [VALUE_BITS-1:0] r_min, r_max, r_cutoff;
    logic                         r_any;
    logic [PW-1:0]                r_prod;
    logic [VALUE_BITS-1:0]        span;
    logic signed [VALUE_BITS-1:0] val_value;
    logic                         val_old, thr_bit;

    // Memories.
    logic [VALUE_BITS:0] val_rdata;
    logic                abv_rdata, new_rdata;
    logic                val_we, abv_we, abv_wdata, new_we, new_wdata;
    logic [AW-1:0]       new_raddr;

    // Readout pipeline.
    logic               r_q_valid, r_q_last, r_q_clear;
    logic               r_out_valid, r_out_bit, r_out_last;
    logic [TOTAL_W-1:0] r_out_total;

    function automatic logic signed [OW-1:0] stride_of(t_axis ax, logic [LW-1:0] e,
                                                       logic [2*LW-1:0] p);
        logic signed [OW-1:0] s;
        unique case (ax)
            AX_K:    s = OW'(1);
            AX_J:    s = OW'(e);
            AX_I:    s = OW'(p);
            default: s = OW'(1);
        endcase
        return s;
    endfunction

    assign len_ext = EW'(r_cube_len);

    always_comb begin
        priority if (len_ext == '0) begin
            edge_len = LW'(1);
        end else if (len_ext > EW'(MAX_LEN)) begin
            edge_len = LW'(MAX_LEN);
        end else begin
            edge_len = LW'(len_ext);
        end
    end

    assign busy        = (r_state != ST_IDLE);
    assign load_acc    = start && !busy && (t_cmd'(i_cmd) == CMD_LOAD);
    assign read_acc    = start && !busy && (t_cmd'(i_cmd) == CMD_READ);
    assign cfg_size_wr = i_cfg_we && (t_cfg_idx'(i_cfg_index) == CFG_CUBE_LEN);

    assign ld_pos   = (CW'(r_load_pos) >= r_cells) ? '0 : r_load_pos;
    assign ld_final = (CW'(ld_pos) + CW'(1)) >= r_cells;
    assign rd_wrap  = CW'(r_read_pos) >= r_cells;
    assign rd_pos   = rd_wrap ? '0 : r_read_pos;
    assign rd_last  = (CW'(rd_pos) + CW'(1)) >= r_cells;

    // Sweep address generation.
    assign is_dil     = (r_state == ST_DILATE);
    assign issue      = ((r_state == ST_RANGE) || (r_state == ST_THRESH) || is_dil) && !r_swept;
    assign cur_stride = stride_of(r_axis, r_edge, r_plane);
    assign base_cur   = -($signed(OW'(DILATE_RADIUS)) * cur_stride);
    assign base_next  = -($signed(OW'(DILATE_RADIUS)) * stride_of(next_axis, r_edge, r_plane));
    assign last_tap   = !is_dil || (r_tap == TW'(NT - 1));
    assign voxel_final = CW'(r_pos) == (r_cells - CW'(1));
    assign edge_m1    = XW'(r_edge - LW'(1));
    assign sweep_addr = is_dil ? AW'(OW'(r_pos) + r_off) : r_pos;

    always_comb begin
        unique case (r_axis)
            AX_K:    coord_sel = r_ck;
            AX_J:    coord_sel = r_cj;
            AX_I:    coord_sel = r_ci;
            default: coord_sel = r_ck;
        endcase
    end

    assign tap_sum = SW'(coord_sel) + SW'(r_tap);
    assign tap_ok  = (tap_sum >= SW'(DILATE_RADIUS)) &&
                     (tap_sum < (SW'(r_edge) + SW'(DILATE_RADIUS)));

    assign p_done = r_p_valid && r_p_final;

    // Data returned from the memories.
    assign val_old   = val_rdata[VALUE_BITS];
    assign val_value = $signed(val_rdata[VALUE_BITS-1:0]);
    assign thr_bit   = r_any && (val_value >= r_cutoff);
    assign span      = VALUE_BITS'(r_max - r_min);
    assign hit       = r_acc | (r_p_ok & ((r_axis == AX_J) ? new_rdata : abv_rdata));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_SIZE1: begin
                n_state = ST_SIZE2;
            end
            ST_SIZE2: begin
                n_state = ST_IDLE;
            end
            ST_IDLE: begin
                priority if (cfg_size_wr) begin
                    n_state = ST_SIZE1;
                end else if (load_acc && ld_final) begin
                    n_state = ST_RANGE;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_RANGE: begin
                if (p_done) n_state = ST_MULT;
            end
            ST_MULT: begin
                n_state = ST_CUT;
            end
            ST_CUT: begin
                n_state = ST_THRESH;
            end
            ST_THRESH: begin
                if (p_done) n_state = ST_DILATE;
            end
            ST_DILATE: begin
                if (p_done && (r_axis == AX_I)) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (cfg_size_wr && ((r_state == ST_SIZE1) || (r_state == ST_SIZE2))) begin
            n_state = ST_SIZE1;
        end
    end

    always_comb begin
        sweep_start = 1'b0;
        next_axis   = AX_K;
        val_we      = load_acc;
        abv_we      = 1'b0;
        abv_wdata   = hit;
        new_we      = 1'b0;
        new_wdata   = hit;
        new_raddr   = rd_pos;
        unique case (r_state)
            ST_IDLE: begin
                sweep_start = load_acc && ld_final;
            end
            ST_CUT: begin
                sweep_start = 1'b1;
            end
            ST_THRESH: begin
                sweep_start = p_done;
                abv_we      = r_p_valid;
                abv_wdata   = thr_bit;
            end
            ST_DILATE: begin
                new_raddr = sweep_addr;
                if (r_axis == AX_J) begin
                    abv_we = r_p_valid && r_p_last;
                end else begin
                    new_we = r_p_valid && r_p_last;
                end
                sweep_start = p_done && (r_axis != AX_I);
                next_axis   = (r_axis == AX_K) ? AX_J : AX_I;
            end
            default: begin
                sweep_start = 1'b0;
            end
        endcase
    end

    stdil_ram #(.W(VALUE_BITS + 1), .DEPTH(CELLS), .AW(AW)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (ld_pos),
        .i_wdata ({i_support_bit, i_voxel_value}),
        .i_raddr (sweep_addr),
        .o_rdata (val_rdata)
    );

    stdil_ram #(.W(1), .DEPTH(CELLS), .AW(AW)) u_abv_ram (
        .i_clk   (i_clk),
        .i_we    (abv_we),
        .i_waddr (r_p_addr),
        .i_wdata (abv_wdata),
        .i_raddr (sweep_addr),
        .o_rdata (abv_rdata)
    );

    stdil_ram #(.W(1), .DEPTH(CELLS), .AW(AW)) u_new_ram (
        .i_clk   (i_clk),
        .i_we    (new_we),
        .i_waddr (r_p_addr),
        .i_wdata (new_wdata),
        .i_raddr (new_raddr),
        .o_rdata (new_rdata)
    );

    assign n_count = (r_q_clear ? '0 : r_count) + TOTAL_W'(new_rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SIZE1;
            r_cube_len  <= CUBE_LEN_RST;
            r_frac      <= FRAC_RST;
            r_edge      <= LW'(1);
            r_plane     <= '0;
            r_cells     <= '0;
            r_load_pos  <= '0;
            r_read_pos  <= '0;
            r_count     <= '0;
            r_pos       <= '0;
            r_ci        <= '0;
            r_cj        <= '0;
            r_ck        <= '0;
            r_tap       <= '0;
            r_off       <= '0;
            r_axis      <= AX_K;
            r_swept     <= 1'b0;
            r_p_valid   <= 1'b0;
            r_acc       <= 1'b0;
            r_min       <= VALUE_MAX;
            r_max       <= '0;
            r_any       <= 1'b0;
            r_q_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_CUBE_LEN: r_cube_len <= i_cfg_data[CUBE_LEN_W-1:0];
                    CFG_FRACTION: r_frac     <= i_cfg_data[FRAC_W-1:0];
                    default:      r_frac     <= r_frac;
                endcase
            end

            if (r_state == ST_SIZE1) begin
                r_edge  <= edge_len;
                r_plane <= (2*LW)'(edge_len) * (2*LW)'(edge_len);
            end
            if (r_state == ST_SIZE2) begin
                r_cells <= CW'(r_plane) * CW'(r_edge);
            end

            if (load_acc) begin
                r_load_pos <= ld_final ? r_load_pos : ld_pos + AW'(1);
            end
            if (read_acc) begin
                r_read_pos <= rd_last ? '0 : rd_pos + AW'(1);
            end

            if (sweep_start) begin
                r_pos   <= '0;
                r_ci    <= '0;
                r_cj    <= '0;
                r_ck    <= '0;
                r_tap   <= '0;
                r_off   <= base_next;
                r_axis  <= next_axis;
                r_swept <= 1'b0;
            end else if (issue) begin
                if (last_tap) begin
                    r_tap <= '0;
                    r_off <= base_cur;
                    r_pos <= r_pos + AW'(1);
                    if (voxel_final) r_swept <= 1'b1;
                    if (r_ck == edge_m1) begin
                        r_ck <= '0;
                        if (r_cj == edge_m1) begin
                            r_cj <= '0;
                            r_ci <= r_ci + XW'(1);
                        end else begin
                            r_cj <= r_cj + XW'(1);
                        end
                    end else begin
                        r_ck <= r_ck + XW'(1);
                    end
                end else begin
                    r_tap <= r_tap + TW'(1);
                    r_off <= r_off + cur_stride;
                end
            end

            r_p_valid <= issue && !sweep_start;

            if (is_dil && r_p_valid) begin
                r_acc <= r_p_last ? 1'b0 : hit;
            end

            if (r_state == ST_IDLE && load_acc && ld_final) begin
                r_min <= VALUE_MAX;
                r_max <= '0;
                r_any <= 1'b0;
            end else if (r_state == ST_RANGE && r_p_valid && val_old &&
                         (val_value >= 0)) begin
                r_any <= 1'b1;
                if (val_value > r_max) r_max <= val_value;
                if (val_value < r_min) r_min <= val_value;
            end

            if (is_dil && p_done && (r_axis == AX_I)) begin
                r_load_pos <= '0;
                r_read_pos <= '0;
                r_count    <= '0;
            end else if (r_q_valid) begin
                r_count <= r_q_last ? '0 : n_count;
            end

            r_q_valid   <= read_acc;
            r_out_valid <= r_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_ok    <= !is_dil || tap_ok;
        r_p_last  <= last_tap;
        r_p_final <= last_tap && voxel_final;
        r_p_addr  <= r_pos;
        r_q_last  <= rd_last;
        r_q_clear <= rd_wrap;
        if (r_state == ST_MULT) begin
            r_prod <= PW'(span) * PW'(r_frac);
        end
        if (r_state == ST_CUT) begin
            r_cutoff <= r_min + $signed(r_prod[PW-1:FRAC_W]);
        end
        if (r_q_valid) begin
            r_out_bit   <= new_rdata;
            r_out_last  <= r_q_last;
            r_out_total <= n_count;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_new_support   = r_out_bit;
    assign o_last_voxel    = r_out_last;
    assign o_support_total = r_out_total;

    `STDIL_ASSERT(a_no_read_in_dilate, i_clk, i_rst_n, (r_state == ST_DILATE) |-> !r_q_valid, "readout in flight during dilation")
    `STDIL_ASSERT(a_write_in_cube, i_clk, i_rst_n, r_p_valid |-> (CW'(r_p_addr) < r_cells), "sweep write address outside the cube")
    `STDIL_ASSERT_CLK(a_last_clears_count, i_clk, (i_rst_n && r_out_valid && r_out_last) |-> (r_count == '0), "count not cleared after final voxel")

endmodule

### dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import stdil_pkg::*;

    localparam int CELLS    = MAX_LEN_DEF * MAX_LEN_DEF * MAX_LEN_DEF;
    localparam int WD_LIMIT = 20000;

    typedef struct packed {
        logic        new_support;
        logic        last_voxel;
        logic [15:0] support_total;
    } t_bit_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    t_cmd                   i_cmd = CMD_LOAD;
    logic signed [23:0]     i_voxel_value = '0;
    logic                   i_support_bit = 1'b0;
    logic                   i_cfg_we = 1'b0;
    t_cfg_idx               i_cfg_index = CFG_CUBE_LEN;
    logic [15:0]            i_cfg_data = '0;
    logic                   o_valid;
    logic                   o_new_support;
    logic                   o_last_voxel;
    logic [15:0]            o_support_total;

    support_threshold_dilate DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cmd(i_cmd), .i_voxel_value(i_voxel_value), .i_support_bit(i_support_bit),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_new_support(o_new_support), .o_last_voxel(o_last_voxel),
        .o_support_total(o_support_total)
    );

    always #4 i_clk = ~i_clk;

    // Shadow state of the support update.
    logic [5:0]         sh_len = CUBE_LEN_RST;
    logic [15:0]        sh_frac = FRAC_RST;
    logic signed [23:0] sh_value [CELLS];
    bit                 sh_old [CELLS];
    bit                 sh_above [CELLS];
    bit                 sh_new [CELLS];
    int unsigned        sh_load_pos = 0;
    int unsigned        sh_read_pos = 0;
    int unsigned        sh_count = 0;
    int unsigned        sh_updated_n = 0;

    t_bit_result        support_q [$];
    int                 errors = 0;
    int                 n_loads = 0;
    int                 n_reads = 0;
    int                 n_updates = 0;
    int                 n_results = 0;
    int                 gap_pct = 25;

    function automatic int unsigned edge_len();
        int unsigned l;
        l = sh_len;
        if (l == 0) l = 1;
        if (l > MAX_LEN_DEF) l = MAX_LEN_DEF;
        return l;
    endfunction

    function automatic void update_support();
        int l, a, b, c, i, j, k;
        int unsigned n;
        logic signed [23:0] lo, hi;
        longint cutoff;
        bit qual, hit;
        l = edge_len();
        n = l * l * l;
        lo = 24'sh7FFFFF;
        hi = '0;
        qual = 0;
        cutoff = 0;
        for (int v = 0; v < n; v++) begin
            if (sh_old[v] && sh_value[v] >= 0) begin
                qual = 1;
                if (sh_value[v] > hi) hi = sh_value[v];
                if (sh_value[v] < lo) lo = sh_value[v];
            end
        end
        if (qual)
            cutoff = longint'(lo) + (((longint'(hi) - longint'(lo)) * longint'(sh_frac)) >>> 16);
        for (int v = 0; v < n; v++)
            sh_above[v] = qual && (longint'(sh_value[v]) >= cutoff);
        for (i = 0; i < l; i++)
            for (j = 0; j < l; j++)
                for (k = 0; k < l; k++) begin
                    hit = 0;
                    for (a = i - 1; a <= i + 1; a++)
                        for (b = j - 1; b <= j + 1; b++)
                            for (c = k - 1; c <= k + 1; c++)
                                if (a >= 0 && a < l && b >= 0 && b < l && c >= 0 && c < l)
                                    if (sh_above[(a * l + b) * l + c]) hit = 1;
                    sh_new[(i * l + j) * l + k] = hit;
                end
        sh_load_pos = 0;
        sh_read_pos = 0;
        sh_count = 0;
        sh_updated_n = n;
        n_updates++;
    endfunction

    function automatic void predict(t_cmd c, logic signed [23:0] v, bit s);
        int unsigned n;
        t_bit_result r;
        n = edge_len() ** 3;
        if (c == CMD_LOAD) begin
            if (sh_load_pos >= n) sh_load_pos = 0;
            sh_value[sh_load_pos] = v;
            sh_old[sh_load_pos] = s;
            n_loads++;
            if (sh_load_pos + 1 >= n) update_support();
            else sh_load_pos++;
        end else begin
            if (sh_read_pos >= n) begin
                sh_read_pos = 0;
                sh_count = 0;
            end
            r.new_support = sh_new[sh_read_pos];
            r.last_voxel = (sh_read_pos + 1 >= n);
            if (r.new_support) sh_count++;
            r.support_total = sh_count[15:0];
            support_q.push_back(r);
            n_reads++;
            if (r.last_voxel) begin
                sh_read_pos = 0;
                sh_count = 0;
            end else begin
                sh_read_pos++;
            end
        end
    endfunction

    function automatic bit can_read();
        return sh_updated_n >= edge_len() ** 3;
    endfunction

    task automatic send_request(input t_cmd c, input logic signed [23:0] v, input bit s);
        int g;
        start <= 1'b1;
        i_cmd <= c;
        i_voxel_value <= v;
        i_support_bit <= s;
        do @(posedge i_clk); while (busy);
        predict(c, v, s);
        if ($urandom_range(0, 99) < gap_pct) begin
            g = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
            start <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (support_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] d);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_CUBE_LEN) sh_len = d[5:0];
        else sh_frac = d;
    endtask

    function automatic logic signed [23:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return 24'($urandom_range(0, 255));
            3: return -24'sd1 - 24'($urandom_range(0, 1000));
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic load_cube(input int reads_mix);
        int unsigned n;
        n = edge_len() ** 3;
        for (int unsigned v = 0; v < n; v++) begin
            if (reads_mix > 0 && can_read() && $urandom_range(0, 99) < reads_mix)
                send_request(CMD_READ, 24'($urandom), $urandom_range(0, 1));
            send_request(CMD_LOAD, rand_value(), $urandom_range(0, 3) != 0);
        end
    endtask

    task automatic read_bits(input int unsigned count);
        repeat (count) send_request(CMD_READ, 24'($urandom), $urandom_range(0, 1));
    endtask

    task automatic test_single_voxel();
        write_reg(CFG_CUBE_LEN, 16'd0);
        write_reg(CFG_FRACTION, 16'd0);
        send_request(CMD_LOAD, 24'sh7FFFFF, 1'b1);
        read_bits(3);
        write_reg(CFG_FRACTION, 16'hFFFF);
        send_request(CMD_LOAD, 24'sh800000, 1'b1);
        read_bits(2);
        send_request(CMD_LOAD, 24'sd0, 1'b1);
        read_bits(2);
    endtask

    task automatic test_no_qualifier();
        write_reg(CFG_CUBE_LEN, 16'd2);
        for (int v = 0; v < 8; v++)
            send_request(CMD_LOAD, (v % 2) ? 24'sh7FFFFF : 24'sh800000, v % 2 == 0);
        read_bits(9);
    endtask

    task automatic test_shrink();
        write_reg(CFG_CUBE_LEN, 16'd4);
        write_reg(CFG_FRACTION, 16'd32768);
        for (int v = 0; v < 64; v++)
            send_request(CMD_LOAD, 24'($urandom_range(0, 1000)), (v % 7) == 0);
        read_bits(20);
        for (int v = 0; v < 40; v++)
            send_request(CMD_LOAD, 24'($urandom_range(0, 1000)), 1'b1);
        write_reg(CFG_CUBE_LEN, 16'd2);
        read_bits(3);
        send_request(CMD_LOAD, 24'sd500, 1'b1);
        read_bits(9);
    endtask

    task automatic test_random();
        logic [15:0] f;
        while (n_loads + n_reads < 1000) begin
            gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
            write_reg(CFG_CUBE_LEN, 16'($urandom_range(0, 9) == 0 ? 1 : $urandom_range(2, 5)));
            case ($urandom_range(0, 3))
                0: f = 16'd0;
                1: f = 16'hFFFF;
                default: f = 16'($urandom);
            endcase
            write_reg(CFG_FRACTION, f);
            load_cube(10);
            read_bits(edge_len() ** 3 + $urandom_range(0, 10));
        end
    endtask

    task automatic test_clamped_len();
        gap_pct = 10;
        write_reg(CFG_CUBE_LEN, 16'd3);
        write_reg(CFG_FRACTION, FRAC_RST);
        load_cube(0);
        write_reg(CFG_CUBE_LEN, 16'd63);
        read_bits(20);
        for (int v = 0; v < 30; v++)
            send_request(CMD_LOAD, rand_value(), 1'b1);
        write_reg(CFG_CUBE_LEN, 16'd3);
        read_bits(10);
    endtask

    always @(posedge i_clk) begin
        t_bit_result r;
        if (i_rst_n && o_valid) begin
            n_results++;
            if (support_q.size() == 0) begin
                $display("%0t: unexpected result %b %b %0d", $time, o_new_support,
                         o_last_voxel, o_support_total);
                errors++;
            end else begin
                r = support_q.pop_front();
                if (o_new_support !== r.new_support) begin
                    $display("%0t: new_support expected %b actual %b", $time,
                             r.new_support, o_new_support);
                    errors++;
                end
                if (o_last_voxel !== r.last_voxel) begin
                    $display("%0t: last_voxel expected %b actual %b", $time,
                             r.last_voxel, o_last_voxel);
                    errors++;
                end
                if (o_support_total !== r.support_total) begin
                    $display("%0t: support_total expected %0d actual %0d", $time,
                             r.support_total, o_support_total);
                    errors++;
                end
            end
        end
    end

    int stall_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WD_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_single_voxel();
        test_no_qualifier();
        test_shrink();
        test_random();
        test_clamped_len();
        wait_idle();
        repeat (10) @(posedge i_clk);
        $display("Covered %0d loads, %0d reads, %0d support updates, %0d results checked.",
                 n_loads, n_reads, n_updates, n_results);
        if (errors == 0 && support_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/stdil_pkg.sv
rtl/stdil_ram.sv
rtl/support_threshold_dilate.sv
dv/tb.sv
